### rtl/core/arpc_pkg.sv
// Package for the ARP cache engine: result kinds, register indexes, defaults.
// No dependencies.
package arpc_pkg;
    localparam int ENTRIES_DEF    = 16;
    localparam int MAX_HW_LEN_DEF = 6;

    localparam logic [3:0] K_IGNORED    = 4'd0;
    localparam logic [3:0] K_HIT        = 4'd1;
    localparam logic [3:0] K_QUENCH     = 4'd2;
    localparam logic [3:0] K_SEND_REQ   = 4'd3;
    localparam logic [3:0] K_ARP_REPLY  = 4'd4;
    localparam logic [3:0] K_RARP_REPLY = 4'd5;
    localparam logic [3:0] K_BAD_TYPE   = 4'd6;
    localparam logic [3:0] K_BAD_LEN    = 4'd7;
    localparam logic [3:0] K_BAD_ADDR   = 4'd8;
    localparam logic [3:0] K_FULL       = 4'd9;
    localparam logic [3:0] K_FLUSH      = 4'd10;
    localparam logic [3:0] K_ADDED      = 4'd11;

    localparam logic [1:0] OP_RESOLVE = 2'd0;
    localparam logic [1:0] OP_PACKET  = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_STATIC  = 2'd3;

    localparam logic [2:0] R_MY_IP   = 3'd0;
    localparam logic [2:0] R_MY_MAC  = 3'd1;
    localparam logic [2:0] R_BCAST   = 3'd2;
    localparam logic [2:0] R_HW_TYPE = 3'd3;
    localparam logic [2:0] R_PROTO   = 3'd4;
    localparam logic [2:0] R_PEND    = 3'd5;
    localparam logic [2:0] R_LIFE    = 3'd6;

    localparam logic [15:0] OPC_ARP_REQ  = 16'd1;
    localparam logic [15:0] OPC_ARP_REP  = 16'd2;
    localparam logic [15:0] OPC_RARP_REQ = 16'd3;
    localparam logic [15:0] OPC_RARP_REP = 16'd4;

    typedef struct packed {
        logic [3:0]  kind;
        logic [47:0] dest_mac;
        logic [15:0] opcode;
        logic [47:0] smac;
        logic [31:0] sip;
        logic [47:0] tmac;
        logic [31:0] tip;
    } t_res;
endpackage

### rtl/core/arp_cache_engine_core.sv
// ARP cache engine top level: sequencer that scans the slot table one entry a cycle.
// Depends on arpc_pkg.
//
//  channel  | handshake            | payload
//  command  | i_start / o_busy     | i_op .. i_publish
//  result   | o_valid (no stall)   | o_kind .. o_out_target_ip, o_last
//  config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One scan pass over all ENTRIES slots (one slot per cycle), then S_FIN registers
// the first result word; a second word, if any, follows from S_OUT2 in the next
// cycle. A new command is accepted only in S_IDLE, after the last word. Reset
// clears slot flags, config registers and state; slot payload is held in flops.
// Results cannot be stalled; busy drops in the cycle of the last word.
module arp_cache_engine_core #(
    parameter int ENTRIES    = arpc_pkg::ENTRIES_DEF,
    parameter int MAX_HW_LEN = arpc_pkg::MAX_HW_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_hardware,
    input  logic [15:0] i_protocol,
    input  logic [7:0]  i_hw_len,
    input  logic [7:0]  i_pr_len,
    input  logic [15:0] i_opcode,
    input  logic [47:0] i_sender_mac,
    input  logic [31:0] i_sender_ip,
    input  logic [47:0] i_target_mac,
    input  logic [31:0] i_target_ip,
    input  logic        i_publish,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    output logic        o_valid,
    output logic [3:0]  o_kind,
    output logic [47:0] o_dest_mac,
    output logic [15:0] o_out_opcode,
    output logic [47:0] o_out_sender_mac,
    output logic [31:0] o_out_sender_ip,
    output logic [47:0] o_out_target_mac,
    output logic [31:0] o_out_target_ip,
    output logic        o_last
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(ENTRIES - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN1 = 3'd1;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_OUT2  = 3'd5;

    // config
    logic [31:0] r_my_ip;
    logic [47:0] r_my_mac, r_bcast;
    logic [15:0] r_hw_type, r_proto, r_pend, r_life;

    // slot table
    logic [ENTRIES-1:0] r_used, r_res, r_stat, r_pub;
    logic [31:0] r_sip [ENTRIES];
    logic [47:0] r_smac [ENTRIES];
    logic [15:0] r_tk [ENTRIES];

    // item
    logic [1:0]  r_op;
    logic [15:0] r_opc;
    logic [47:0] r_smac_in, r_tmac_in;
    logic [31:0] r_sip_in, r_tip_in;
    logic        r_pubin;
    logic        r_bad_type, r_bad_len;

    logic [2:0]    r_st;
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] idx;
    assign idx = r_cnt[IW-1:0];

    // scan results
    logic          r_fa, r_ft, r_ff, r_fr;    // found: sender/key, target, free, rarp
    logic [IW-1:0] r_ia, r_it, r_if, r_ir;

    arpc_pkg::t_res r_res2, r_out;
    logic   r_ov, r_olast;

    logic [15:0] pend_l, life_l;
    assign pend_l = (r_pend == 16'd0) ? 16'd1 : r_pend;
    assign life_l = (r_life == 16'd0) ? 16'd1 : r_life;

    logic [31:0] key;
    assign key = (r_op == arpc_pkg::OP_RESOLVE) ? r_tip_in : r_sip_in;

    function automatic arpc_pkg::t_res mk(input logic [3:0] k, input logic [31:0] tip);
        arpc_pkg::t_res r;
        r = '0;
        r.kind = k;
        r.tip = tip;
        return r;
    endfunction

    assign o_busy = (r_st != S_IDLE);
    assign o_valid = r_ov;
    assign o_kind = r_out.kind;
    assign o_dest_mac = r_out.dest_mac;
    assign o_out_opcode = r_out.opcode;
    assign o_out_sender_mac = r_out.smac;
    assign o_out_sender_ip = r_out.sip;
    assign o_out_target_mac = r_out.tmac;
    assign o_out_target_ip = r_out.tip;
    assign o_last = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_ip <= '0; r_my_mac <= '0; r_bcast <= '1;
            r_hw_type <= 16'd1; r_proto <= 16'h0800; r_pend <= 16'd15; r_life <= 16'd900;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                arpc_pkg::R_MY_IP:   r_my_ip <= i_cfg_data[31:0];
                arpc_pkg::R_MY_MAC:  r_my_mac <= i_cfg_data;
                arpc_pkg::R_BCAST:   r_bcast <= i_cfg_data;
                arpc_pkg::R_HW_TYPE: r_hw_type <= i_cfg_data[15:0];
                arpc_pkg::R_PROTO:   r_proto <= i_cfg_data[15:0];
                arpc_pkg::R_PEND:    r_pend <= i_cfg_data[15:0];
                arpc_pkg::R_LIFE:    r_life <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // one slot write port, used by the final step
    logic          w_en, w_used, w_res, w_stat, w_pub;
    logic [IW-1:0] w_idx;
    logic [47:0]   w_mac;
    logic [15:0]   w_tk;
    logic [31:0]   w_ip;
    logic          w_newip;
    arpc_pkg::t_res o1, o2;
    logic          has2;

    always_comb begin
        logic learned_pend, known;
        w_en = 1'b0; w_idx = r_ia; w_used = 1'b1; w_res = 1'b1; w_stat = 1'b0; w_pub = 1'b0;
        w_mac = r_smac_in; w_tk = life_l; w_ip = key; w_newip = 1'b0;
        o1 = mk(arpc_pkg::K_IGNORED, 32'd0); o2 = o1; has2 = 1'b0;
        learned_pend = 1'b0; known = r_fa;
        unique case (r_op)
            arpc_pkg::OP_RESOLVE: begin
                if (r_fa && r_res[r_ia]) begin
                    o1 = mk(arpc_pkg::K_HIT, 32'd0);
                    o1.dest_mac = r_smac[r_ia];
                end else if (r_fa) begin
                    o1 = mk(arpc_pkg::K_QUENCH, r_tip_in);
                end else if (!r_ff) begin
                    o1 = mk(arpc_pkg::K_FULL, r_tip_in);
                end else begin
                    w_en = 1'b1; w_idx = r_if; w_res = 1'b0; w_mac = '0; w_tk = pend_l;
                    w_newip = 1'b1;
                    o1 = mk(arpc_pkg::K_SEND_REQ, r_tip_in);
                    o1.dest_mac = r_bcast; o1.opcode = arpc_pkg::OPC_ARP_REQ;
                    o1.smac = r_my_mac; o1.sip = r_my_ip;
                end
            end
            arpc_pkg::OP_PACKET: begin
                if (r_bad_type) o1 = mk(arpc_pkg::K_BAD_TYPE, 32'd0);
                else if (r_bad_len) o1 = mk(arpc_pkg::K_BAD_LEN, 32'd0);
                else if (r_smac_in == r_bcast) o1 = mk(arpc_pkg::K_BAD_ADDR, 32'd0);
                else begin
                    arpc_pkg::t_res a;
                    logic ha;
                    a = mk(arpc_pkg::K_IGNORED, 32'd0); ha = 1'b0;
                    if (known && !r_stat[r_ia]) begin
                        w_en = 1'b1;
                        learned_pend = !r_res[r_ia];
                    end
                    if (r_tip_in == r_my_ip) begin
                        if (!known) begin
                            if (!r_ff) begin
                                a = mk(arpc_pkg::K_FULL, r_sip_in); ha = 1'b1;
                            end else begin
                                w_en = 1'b1; w_idx = r_if; w_newip = 1'b1;
                            end
                        end
                        if (r_opc == arpc_pkg::OPC_ARP_REQ) begin
                            arpc_pkg::t_res b;
                            b = mk(arpc_pkg::K_ARP_REPLY, r_sip_in);
                            b.dest_mac = r_smac_in; b.opcode = arpc_pkg::OPC_ARP_REP;
                            b.smac = r_my_mac; b.sip = r_my_ip; b.tmac = r_smac_in;
                            if (ha) begin o2 = b; has2 = 1'b1; end
                            else begin a = b; ha = 1'b1; end
                        end
                    end else if (r_opc == arpc_pkg::OPC_ARP_REQ && r_ft && r_pub[r_it]) begin
                        // a published entry is static, so learning never touched it
                        a = mk(arpc_pkg::K_ARP_REPLY, r_sip_in);
                        a.dest_mac = r_smac_in; a.opcode = arpc_pkg::OPC_ARP_REP;
                        a.smac = r_smac[r_it]; a.sip = r_sip[r_it]; a.tmac = r_smac_in;
                        ha = 1'b1;
                    end else if (r_opc == arpc_pkg::OPC_RARP_REQ && r_fr && r_pub[r_ir]) begin
                        a = mk(arpc_pkg::K_RARP_REPLY, r_sip[r_ir]);
                        a.dest_mac = r_tmac_in; a.opcode = arpc_pkg::OPC_RARP_REP;
                        a.smac = r_my_mac; a.sip = r_my_ip; a.tmac = r_tmac_in;
                        ha = 1'b1;
                    end
                    if (learned_pend) begin
                        o1 = mk(arpc_pkg::K_FLUSH, r_sip_in);
                        if (ha) begin o2 = a; has2 = 1'b1; end
                    end else if (ha) begin
                        o1 = a;
                    end
                end
            end
            arpc_pkg::OP_TICK: ;
            default: begin
                w_stat = 1'b1; w_pub = r_pubin; w_tk = '0;
                if (r_fa) begin
                    w_en = 1'b1;
                    o2 = mk(arpc_pkg::K_ADDED, r_sip_in);
                    if (!r_res[r_ia]) begin o1 = mk(arpc_pkg::K_FLUSH, r_sip_in); has2 = 1'b1; end
                    else o1 = o2;
                end else if (r_ff) begin
                    w_en = 1'b1; w_idx = r_if; w_newip = 1'b1;
                    o1 = mk(arpc_pkg::K_ADDED, r_sip_in);
                end else begin
                    o1 = mk(arpc_pkg::K_FULL, r_sip_in);
                end
            end
        endcase
    end

    // scan hit tests at the current index
    logic hit_key, hit_tip, hit_free, hit_rarp;
    assign hit_key  = r_used[idx] && (r_sip[idx] == key);
    assign hit_tip  = r_used[idx] && (r_sip[idx] == r_tip_in);
    assign hit_free = !r_used[idx];
    // a dynamic sender slot is compared as it stands after learning
    assign hit_rarp = r_used[idx] &&
                      ((hit_key && !r_stat[idx]) ? (r_smac_in == r_tmac_in) :
                       (r_res[idx] && (r_smac[idx] == r_tmac_in)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0; r_olast <= 1'b0;
            r_used <= '0; r_res <= '0; r_stat <= '0; r_pub <= '0;
            r_cnt <= '0;
            r_fa <= 1'b0; r_ft <= 1'b0; r_ff <= 1'b0; r_fr <= 1'b0;
        end else begin
            r_ov <= 1'b0;
            r_olast <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        r_op <= i_op; r_opc <= i_opcode; r_smac_in <= i_sender_mac;
                        r_tmac_in <= i_target_mac; r_sip_in <= i_sender_ip;
                        r_tip_in <= i_target_ip; r_pubin <= i_publish;
                        r_bad_type <= (i_hardware != r_hw_type) || (i_protocol != r_proto);
                        r_bad_len <= (i_hw_len > 8'(MAX_HW_LEN)) || (i_pr_len != 8'd4);
                        r_fa <= 1'b0; r_ft <= 1'b0; r_ff <= 1'b0; r_fr <= 1'b0;
                        r_cnt <= '0;
                        r_st <= S_SCAN1;
                    end
                end
                S_SCAN1: begin
                    if (r_op == arpc_pkg::OP_TICK) begin
                        if (r_used[idx] && !r_stat[idx]) begin
                            if (r_tk[idx] <= 16'd1) begin
                                r_tk[idx] <= '0;
                                r_used[idx] <= 1'b0; r_res[idx] <= 1'b0; r_pub[idx] <= 1'b0;
                            end else begin
                                r_tk[idx] <= r_tk[idx] - 16'd1;
                            end
                        end
                    end else begin
                        if (hit_key && !r_fa) begin r_fa <= 1'b1; r_ia <= idx; end
                        if (hit_tip && !r_ft) begin r_ft <= 1'b1; r_it <= idx; end
                        if (hit_free && !r_ff) begin r_ff <= 1'b1; r_if <= idx; end
                        if (hit_rarp && !r_fr) begin r_fr <= 1'b1; r_ir <= idx; end
                    end
                    if (r_cnt == LAST_IDX) r_st <= S_FIN;
                    r_cnt <= r_cnt + CW'(1);
                end
                S_FIN: begin
                    if (w_en) begin
                        r_used[w_idx] <= w_used; r_res[w_idx] <= w_res;
                        r_stat[w_idx] <= w_stat; r_pub[w_idx] <= w_pub;
                        r_smac[w_idx] <= w_mac; r_tk[w_idx] <= w_tk;
                        if (w_newip) r_sip[w_idx] <= w_ip;
                    end
                    r_out <= o1; r_ov <= 1'b1; r_olast <= !has2;
                    r_res2 <= o2;
                    r_st <= has2 ? S_OUT2 : S_IDLE;
                end
                S_OUT2: begin
                    r_out <= r_res2; r_ov <= 1'b1; r_olast <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
